>>> rtl/dsrb_pkg.sv
// Shared types and constants for the daily sample ring buffer.
package dsrb_pkg;

    // Fixed field widths
    localparam int TIME_W  = 32;
    localparam int WATTS_W = 20;
    localparam int POWER_W = 16;
    localparam int IDX_W   = 9;
    localparam int COUNT_W = 9;
    localparam int DAY_W   = 16;

    localparam int DEF_CAPACITY = 288;

    // Power codes
    localparam logic [POWER_W-1:0] POWER_MAX     = 16'hFFFE;
    localparam logic [POWER_W-1:0] POWER_INVALID = 16'hFFFF;

    // 86400 = 2^7 * 675; day = ((t >> 7) * ceil(2^35 / 675)) >> 35, exact for 25-bit operand
    localparam int SEC_SHIFT   = 7;
    localparam int SECS_HI_W   = TIME_W - SEC_SHIFT;
    localparam int DAY_ODD     = 675;
    localparam int DAY_SHIFT   = 35;
    localparam int DAY_RECIP_W = 26;
    localparam int DAY_PROD_W  = SECS_HI_W + DAY_RECIP_W;
    localparam logic [DAY_RECIP_W-1:0] DAY_RECIP =
        DAY_RECIP_W'(((64'd1 << DAY_SHIFT) + DAY_ODD - 1) / DAY_ODD);

    localparam int SPD_W = 17;
    localparam logic [SPD_W-1:0] SECONDS_PER_DAY = 17'd86400;

    typedef enum logic {
        MODE_APPEND = 1'b0,
        MODE_READ   = 1'b1
    } mode_t;

    // One item after the day stage
    typedef struct packed {
        mode_t              mode;
        logic [TIME_W-1:0]  sample_time;
        logic [POWER_W-1:0] power_code;
        logic [IDX_W-1:0]   read_index;
        logic [DAY_W-1:0]   day;
    } item_t;

endpackage

>>> rtl/dsrb_if.sv
// Valid/ready channel interfaces for sample beats and result beats.
interface dsrb_in_if import dsrb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               mode;
    logic [TIME_W-1:0]  sample_time;
    logic [WATTS_W-1:0] power_watts;
    logic               power_valid;
    logic [IDX_W-1:0]   read_index;

    modport source (
        output valid, mode, sample_time, power_watts, power_valid, read_index,
        input  ready
    );
    modport sink (
        input  valid, mode, sample_time, power_watts, power_valid, read_index,
        output ready
    );
endinterface

interface dsrb_out_if import dsrb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               entry_found;
    logic [TIME_W-1:0]  entry_time;
    logic [POWER_W-1:0] entry_power;
    logic [COUNT_W-1:0] stored_count;
    logic [TIME_W-1:0]  oldest_time;
    logic [TIME_W-1:0]  midnight_time;

    modport source (
        output valid, entry_found, entry_time, entry_power, stored_count,
               oldest_time, midnight_time,
        input  ready
    );
    modport sink (
        input  valid, entry_found, entry_time, entry_power, stored_count,
               oldest_time, midnight_time,
        output ready
    );
endinterface

>>> rtl/dsrb_day_stage.sv
// Input register and day-number stage: divides time by 86400 and encodes power.
module dsrb_day_stage import dsrb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dsrb_in_if.sink     samples,
    output item_t       item,
    output logic        item_valid,
    input  logic        item_ready
);

    logic               s1_valid_reg;
    logic               mode_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [WATTS_W-1:0] watts_reg;
    logic               pvalid_reg;
    logic [IDX_W-1:0]   index_reg;

    item_t              item_reg;
    item_t              item_next;
    logic               s2_valid_reg;

    logic               en1;
    logic               en2;
    logic [SECS_HI_W-1:0]  secs_hi;
    logic [DAY_PROD_W-1:0] day_prod;

    // Stage enables: a stage loads when it is empty or its content moves on
    assign en2 = !s2_valid_reg || item_ready;
    assign en1 = !s1_valid_reg || en2;
    assign samples.ready = en1;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en1)
        begin
            s1_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            mode_reg   <= samples.mode;
            time_reg   <= samples.sample_time;
            watts_reg  <= samples.power_watts;
            pvalid_reg <= samples.power_valid;
            index_reg  <= samples.read_index;
        end
    end

    // Day number by reciprocal multiply, power clamp or invalid code
    always_comb
    begin
        secs_hi  = time_reg[TIME_W-1:SEC_SHIFT];
        day_prod = DAY_PROD_W'(secs_hi) * DAY_PROD_W'(DAY_RECIP);

        item_next.mode        = mode_t'(mode_reg);
        item_next.sample_time = time_reg;
        item_next.read_index  = index_reg;
        item_next.day         = day_prod[DAY_SHIFT +: DAY_W];
        if (!pvalid_reg)
        begin
            item_next.power_code = POWER_INVALID;
        end
        else if (watts_reg > WATTS_W'(POWER_MAX))
        begin
            item_next.power_code = POWER_MAX;
        end
        else
        begin
            item_next.power_code = watts_reg[POWER_W-1:0];
        end
    end

    // Item register toward the ring
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en2)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            item_reg <= item_next;
        end
    end

    assign item       = item_reg;
    assign item_valid = s2_valid_reg;

endmodule

>>> rtl/dsrb_ring.sv
// Ring state, sample memories and the result register.
module dsrb_ring import dsrb_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  item_t       item,
    input  logic        item_valid,
    output logic        item_ready,
    dsrb_out_if.source  results
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = ((AW > IDX_W) ? AW : IDX_W) + 1;
    localparam logic [AW-1:0] LAST_SLOT  = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);
    localparam logic [SW-1:0] CAP_S      = SW'(CAPACITY);

    // Ring state
    logic [AW-1:0]     write_slot_reg, write_slot_next;
    logic [CW-1:0]     held_count_reg, held_count_next;
    logic [DAY_W-1:0]  current_day_reg, current_day_next;
    logic [TIME_W-1:0] midnight_reg, midnight_next;

    // Sample memories
    logic [TIME_W-1:0]  time_mem  [CAPACITY];
    logic [POWER_W-1:0] power_mem [CAPACITY];

    // Result register
    logic               out_valid_reg;
    logic               found_reg, found_next;
    logic [CW-1:0]      count_out_reg;
    logic [TIME_W-1:0]  midnight_out_reg;
    logic               has_oldest_reg;
    logic               bypass_reg, bypass_next;
    logic [TIME_W-1:0]  bypass_time_reg;
    logic [TIME_W-1:0]  entry_time_rd_reg;
    logic [POWER_W-1:0] entry_power_rd_reg;
    logic [TIME_W-1:0]  oldest_time_rd_reg;

    logic                  fire;
    logic                  append;
    logic                  day_change;
    logic [AW-1:0]         base_slot;
    logic [CW-1:0]         base_count;
    logic [TIME_W:0]       mid_prod;
    logic [AW-1:0]         oldest_cur;
    logic [SW-1:0]         slot_sum;
    logic [SW-1:0]         slot_wrap;
    logic [AW-1:0]         entry_addr;
    logic [AW-1:0]         oldest_addr;

    assign item_ready = !out_valid_reg || results.ready;
    assign fire       = item_valid && item_ready;

    // Next ring state and read addresses
    always_comb
    begin
        append     = fire && (item.mode == MODE_APPEND) && (item.sample_time != '0);
        day_change = item.day != current_day_reg;
        base_slot  = day_change ? '0 : write_slot_reg;
        base_count = day_change ? '0 : held_count_reg;
        mid_prod   = (TIME_W + 1)'(item.day) * (TIME_W + 1)'(SECONDS_PER_DAY);

        write_slot_next  = write_slot_reg;
        held_count_next  = held_count_reg;
        current_day_next = current_day_reg;
        midnight_next    = midnight_reg;
        if (append)
        begin
            write_slot_next  = (base_slot == LAST_SLOT) ? '0 : base_slot + 1'b1;
            held_count_next  = (base_count == FULL_COUNT) ? FULL_COUNT : base_count + 1'b1;
            current_day_next = item.day;
            midnight_next    = mid_prod[TIME_W-1:0];
        end

        // Entry lookup: age index from the oldest slot, wrapped once
        found_next = (item.mode == MODE_READ) &&
                     (SW'(item.read_index) < SW'(held_count_reg));
        oldest_cur = (held_count_reg == FULL_COUNT) ? write_slot_reg : '0;
        slot_sum   = SW'(oldest_cur) + SW'(item.read_index);
        slot_wrap  = (slot_sum >= CAP_S) ? slot_sum - CAP_S : slot_sum;
        entry_addr = found_next ? slot_wrap[AW-1:0] : '0;

        // Oldest entry after this beat; forward the write when it lands there
        oldest_addr = (held_count_next == FULL_COUNT) ? write_slot_next : '0;
        bypass_next = append && (base_slot == oldest_addr);
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg  <= '0;
            held_count_reg  <= '0;
            current_day_reg <= '0;
            midnight_reg    <= '0;
        end
        else
        begin
            write_slot_reg  <= write_slot_next;
            held_count_reg  <= held_count_next;
            current_day_reg <= current_day_next;
            midnight_reg    <= midnight_next;
        end
    end

    // Memories: one write port, registered reads
    always_ff @(posedge clk)
    begin
        if (append)
        begin
            time_mem[base_slot]  <= item.sample_time;
            power_mem[base_slot] <= item.power_code;
        end
        if (fire)
        begin
            entry_time_rd_reg  <= time_mem[entry_addr];
            entry_power_rd_reg <= power_mem[entry_addr];
            oldest_time_rd_reg <= time_mem[oldest_addr];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            out_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            found_reg        <= found_next;
            count_out_reg    <= held_count_next;
            midnight_out_reg <= midnight_next;
            has_oldest_reg   <= held_count_next != '0;
            bypass_reg       <= bypass_next;
            bypass_time_reg  <= item.sample_time;
        end
    end

    // Output beat
    assign results.valid         = out_valid_reg;
    assign results.entry_found   = found_reg;
    assign results.entry_time    = found_reg ? entry_time_rd_reg : '0;
    assign results.entry_power   = found_reg ? entry_power_rd_reg : '0;
    assign results.stored_count  = COUNT_W'(count_out_reg);
    assign results.midnight_time = midnight_out_reg;
    assign results.oldest_time   = !has_oldest_reg ? '0 :
                                   (bypass_reg ? bypass_time_reg : oldest_time_rd_reg);

endmodule

>>> rtl/daily_sample_ring_buffer.sv
// Top level of the daily sample ring buffer.
// An accepted sample beat passes the input, item and result registers in turn.
// Throughput: one beat per cycle; the ring update and the two-read-port sample
// memory take a new beat whenever the result register can load; a waiting result stalls the ring stage.
// Reset: write slot, count and day clear at once; the ring reads as empty with no
// clearing pass, and memory contents stay as they were.
module daily_sample_ring_buffer import dsrb_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic        clk,
    input  logic        rst_n,
    dsrb_in_if.sink     samples,
    dsrb_out_if.source  results
);

    item_t item;
    logic  item_valid;
    logic  item_ready;

    // Day number and power code
    dsrb_day_stage u_day_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready)
    );

    // Ring update, lookup and result
    dsrb_ring #(
        .CAPACITY (CAPACITY)
    ) u_ring (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .results    (results)
    );

endmodule
